FILE: design/bgbox_pkg.sv
// Shared types, constants and the channel test for the background mask
// bounding box block. Used by the front, queue, back and top-level files.
// Depends on nothing.
package bgbox_pkg;

  // Pixel and coordinate widths
  localparam int PIX_W     = 8;
  localparam int COORD_W   = 12;
  localparam int WIDTH_W   = 13;
  localparam int TOL_W     = 8;

  // Frame geometry limits
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // Background seed set
  localparam int SEED_COUNT = 5;
  localparam int SUM_W      = PIX_W + $clog2(SEED_COUNT);
  localparam int SCNT_W     = $clog2(SEED_COUNT + 1);
  localparam int SIDX_W     = (SEED_COUNT > 1) ? $clog2(SEED_COUNT) : 1;

  // Configuration register map
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 1'b1;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd640;
  localparam logic [TOL_W-1:0]   TOL_RESET   = 8'd5;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sums_t;

  // One queued job: the foreground pixels of one input, in arrival order
  typedef struct packed {
    logic                                 box_clr;
    logic [SEED_COUNT-1:0]                mask;
    logic [SEED_COUNT-1:0][COORD_W-1:0]   xs;
    logic [SEED_COUNT-1:0][COORD_W-1:0]   ys;
  } entry_t;

  // Exact mean test: |sum - N*p| > N*tol
  function automatic logic chan_far(logic [SUM_W-1:0] sum, logic [PIX_W-1:0] p,
                                    logic [TOL_W-1:0] tol);
    logic [SUM_W-1:0] scaled;
    logic [SUM_W-1:0] lim;
    logic [SUM_W-1:0] diff;
    scaled = SUM_W'(p) * SUM_W'(SEED_COUNT);
    lim    = SUM_W'(tol) * SUM_W'(SEED_COUNT);
    diff   = (sum > scaled) ? (sum - scaled) : (scaled - sum);
    return diff > lim;
  endfunction

  function automatic logic pix_far(sums_t s, pix_t p, logic [TOL_W-1:0] tol);
    return chan_far(s.blue, p.blue, tol) || chan_far(s.green, p.green, tol) ||
           chan_far(s.red, p.red, tol);
  endfunction

endpackage

FILE: design/bgbox_front.sv
// Front end: configuration registers, column/row counters, seed capture and
// foreground classification. Pushes one job per input with results.
// Depends on bgbox_pkg.
module bgbox_front import bgbox_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WIDTH_W-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 frame_start_i,
  input  pix_t                 pix_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output entry_t               entry_o
);

  logic [WIDTH_W-1:0] width_q, width_d;
  logic [TOL_W-1:0]   tol_q, tol_d;
  logic [SCNT_W-1:0]  cnt_q, cnt_d;
  sums_t              sum_q, sum_d;
  logic [COORD_W-1:0] col_q, col_d, row_q, row_d;
  logic               pend_q, pend_d;

  pix_t               seed_pix_q [SEED_COUNT];
  logic [COORD_W-1:0] seed_x_q   [SEED_COUNT];
  logic [COORD_W-1:0] seed_y_q   [SEED_COUNT];

  logic               accept;
  logic [SCNT_W-1:0]  eff_cnt;
  sums_t              eff_sum, new_sum, judge_sum;
  logic [COORD_W-1:0] eff_col, eff_row;
  logic               seed_phase, completes;
  logic [WIDTH_W-1:0] w_clamp, col_inc;
  entry_t             entry;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Apply the frame start before the pixel is handled
  always_comb begin
    eff_cnt    = frame_start_i ? '0 : cnt_q;
    eff_sum    = frame_start_i ? '0 : sum_q;
    eff_col    = frame_start_i ? '0 : col_q;
    eff_row    = frame_start_i ? '0 : row_q;
    seed_phase = eff_cnt < SCNT_W'(SEED_COUNT);
    completes  = eff_cnt == SCNT_W'(SEED_COUNT - 1);
    new_sum.blue  = eff_sum.blue + SUM_W'(pix_i.blue);
    new_sum.green = eff_sum.green + SUM_W'(pix_i.green);
    new_sum.red   = eff_sum.red + SUM_W'(pix_i.red);
    judge_sum  = seed_phase ? new_sum : eff_sum;
  end

  // Classify: whole seed set on completion, else the current pixel alone
  always_comb begin
    entry         = '0;
    entry.box_clr = pend_q || frame_start_i;
    if (completes) begin
      for (int i = 0; i < SEED_COUNT; i++) begin
        if (i == SEED_COUNT - 1) begin
          entry.mask[i] = pix_far(judge_sum, pix_i, tol_q);
          entry.xs[i]   = eff_col;
          entry.ys[i]   = eff_row;
        end else begin
          entry.mask[i] = pix_far(judge_sum, seed_pix_q[i], tol_q);
          entry.xs[i]   = seed_x_q[i];
          entry.ys[i]   = seed_y_q[i];
        end
      end
    end else begin
      entry.mask[0] = !seed_phase && pix_far(judge_sum, pix_i, tol_q);
      entry.xs[0]   = eff_col;
      entry.ys[0]   = eff_row;
    end
  end

  assign push_o  = accept && (entry.mask != '0);
  assign entry_o = entry;

  // Step the counters and the seed set
  always_comb begin
    width_d = width_q;
    tol_d   = tol_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    col_d   = col_q;
    row_d   = row_q;
    pend_d  = pend_q;
    w_clamp = (width_q == '0) ? WIDTH_W'(1) :
              (width_q > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_q;
    col_inc = WIDTH_W'(eff_col) + WIDTH_W'(1);
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH: width_d = cfg_data_i;
        CFG_TOLERANCE:   tol_d   = cfg_data_i[TOL_W-1:0];
      endcase
    end
    if (accept) begin
      pend_d = push_o ? 1'b0 : (pend_q || frame_start_i);
      if (seed_phase) begin
        cnt_d = eff_cnt + SCNT_W'(1);
        sum_d = new_sum;
      end else begin
        cnt_d = eff_cnt;
        sum_d = eff_sum;
      end
      if (col_inc >= w_clamp) begin
        col_d = '0;
        row_d = (eff_row == COORD_W'(MAX_HEIGHT - 1)) ? '0 : eff_row + COORD_W'(1);
      end else begin
        col_d = col_inc[COORD_W-1:0];
        row_d = eff_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
      tol_q   <= TOL_RESET;
      cnt_q   <= '0;
      sum_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      width_q <= width_d;
      tol_q   <= tol_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      col_q   <= col_d;
      row_q   <= row_d;
      pend_q  <= pend_d;
    end
  end

  // Hold seed pixels and their coordinates
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SEED_COUNT; i++) begin
      if (accept && seed_phase && eff_cnt == SCNT_W'(i)) begin
        seed_pix_q[i] <= pix_i;
        seed_x_q[i]   <= eff_col;
        seed_y_q[i]   <= eff_row;
      end
    end
  end

endmodule

FILE: design/bgbox_queue.sv
// Job queue between the front and back ends of the bounding box block.
// Depends on bgbox_pkg for the job type.
module bgbox_queue import bgbox_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_pop;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: design/bgbox_back.sv
// Back end: walks the foreground pixels of each queued job, tracks the
// frame's bounding box and drives the registered result channel.
// Depends on bgbox_pkg.
module bgbox_back import bgbox_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  entry_t             head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COORD_W-1:0] fg_x_o,
  output logic [COORD_W-1:0] fg_y_o,
  output logic [COORD_W-1:0] box_min_x_o,
  output logic [COORD_W-1:0] box_max_x_o,
  output logic [COORD_W-1:0] box_min_y_o,
  output logic [COORD_W-1:0] box_max_y_o,
  output logic               last_of_run_o
);

  logic [SEED_COUNT-1:0] done_q, done_d;
  logic                  bv_q, bv_d;
  logic                  out_valid_q, out_valid_d;
  logic [COORD_W-1:0]    left_q, right_q, top_q, bottom_q;
  logic [COORD_W-1:0]    left_d, right_d, top_d, bottom_d;
  logic [COORD_W-1:0]    x_q, y_q;
  logic                  last_q;

  logic [SEED_COUNT-1:0] act, sel_oh, rest;
  logic [SIDX_W-1:0]     sel;
  logic                  fire, last, bv_eff;
  logic [COORD_W-1:0]    x, y;

  // Pick the earliest pending foreground pixel of the head job
  always_comb begin
    act    = head_i.mask & ~done_q;
    sel    = '0;
    sel_oh = '0;
    for (int i = SEED_COUNT - 1; i >= 0; i--) begin
      if (act[i]) begin
        sel    = SIDX_W'(i);
        sel_oh = '0;
        sel_oh[i] = 1'b1;
      end
    end
    rest = act & ~sel_oh;
    last = rest == '0;
    fire = head_valid_i && (act != '0) && (!out_valid_q || !out_stall_i);
    x    = head_i.xs[sel];
    y    = head_i.ys[sel];
  end

  assign pop_o = fire && last;

  // Update the bounding box; a new frame restarts it
  always_comb begin
    bv_eff      = bv_q && !(head_i.box_clr && done_q == '0);
    bv_d        = bv_q;
    done_d      = done_q;
    left_d      = left_q;
    right_d     = right_q;
    top_d       = top_q;
    bottom_d    = bottom_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (fire) begin
      out_valid_d = 1'b1;
      bv_d        = 1'b1;
      bottom_d    = y;
      done_d      = last ? '0 : (done_q | sel_oh);
      if (!bv_eff) begin
        left_d  = x;
        right_d = x;
        top_d   = y;
      end else begin
        left_d  = (x < left_q) ? x : left_q;
        right_d = (x > right_q) ? x : right_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      bv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      bv_q        <= bv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    left_q   <= left_d;
    right_q  <= right_d;
    top_q    <= top_d;
    bottom_q <= bottom_d;
    if (fire) begin
      x_q    <= x;
      y_q    <= y;
      last_q <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign fg_x_o        = x_q;
  assign fg_y_o        = y_q;
  assign box_min_x_o   = left_q;
  assign box_max_x_o   = right_q;
  assign box_min_y_o   = top_q;
  assign box_max_y_o   = bottom_q;
  assign last_of_run_o = last_q;

endmodule

FILE: design/background_mask_bounding_box_core.sv
// Background mask bounding box core.
// Pixels arrive in raster order on the input channel (valid/stall), one per
// cycle, with frame_start_i on the first pixel of a frame. The first five
// pixels of a frame form the background; each of them and every later pixel
// that differs from their mean by more than the tolerance in any channel
// is foreground. Each foreground pixel produces one transaction on the
// output channel with its column/row and the running bounding box of the
// frame; last_of_run_o marks the final result of one input pixel.
// Throughput: one pixel per cycle. Results pass the job queue and the output
// register. The fifth pixel of a frame releases up to five results, drained
// one per cycle by the back end; the job queue (QUEUE_DEPTH entries) absorbs
// the burst, and the input stalls only when the queue is full.
// When the receiver stalls, the output register holds its transaction and
// the queue fills; the input then stalls.
// Configuration (image width, tolerance) is written through the cfg port
// while the block is idle. Reset restores width 640 and tolerance 5, clears
// the counters and the queue; the stream starts as a frame at column 0, row 0.
// Depends on bgbox_pkg, bgbox_front, bgbox_queue, bgbox_back.
module background_mask_bounding_box_core import bgbox_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WIDTH_W-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 frame_start_i,
  input  logic [PIX_W-1:0]     blue_i,
  input  logic [PIX_W-1:0]     green_i,
  input  logic [PIX_W-1:0]     red_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [COORD_W-1:0]   fg_x_o,
  output logic [COORD_W-1:0]   fg_y_o,
  output logic [COORD_W-1:0]   box_min_x_o,
  output logic [COORD_W-1:0]   box_max_x_o,
  output logic [COORD_W-1:0]   box_min_y_o,
  output logic [COORD_W-1:0]   box_max_y_o,
  output logic                 last_of_run_o
);

  pix_t   pix;
  logic   q_full, push, pop, head_valid;
  entry_t entry, head;

  assign pix.blue  = blue_i;
  assign pix.green = green_i;
  assign pix.red   = red_i;

  bgbox_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .frame_start_i(frame_start_i),
    .pix_i        (pix),
    .q_full_i     (q_full),
    .push_o       (push),
    .entry_o      (entry)
  );

  bgbox_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (entry),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .data_o (head)
  );

  bgbox_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .fg_x_o       (fg_x_o),
    .fg_y_o       (fg_y_o),
    .box_min_x_o  (box_min_x_o),
    .box_max_x_o  (box_max_x_o),
    .box_min_y_o  (box_min_y_o),
    .box_max_y_o  (box_max_y_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

FILE: design/bgbox_checker.sv
// Port-level checks for the background mask bounding box core, bound to the
// top level. Depends on the top level's port list only.
module bgbox_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] fg_x_o,
  input logic [11:0] fg_y_o,
  input logic [11:0] box_min_x_o,
  input logic [11:0] box_max_x_o,
  input logic [11:0] box_max_y_o,
  input logic        last_of_run_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(fg_x_o) && $stable(fg_y_o) &&
      $stable(last_of_run_o))
    else $error("stalled result changed");

  // Box must enclose the reported pixel column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> box_min_x_o <= fg_x_o && fg_x_o <= box_max_x_o)
    else $error("pixel column outside bounding box");

  // Latest foreground row is the box bottom
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> box_max_y_o == fg_y_o)
    else $error("box bottom differs from pixel row");

endmodule

bind background_mask_bounding_box_core bgbox_checker u_bgbox_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .fg_x_o       (fg_x_o),
  .fg_y_o       (fg_y_o),
  .box_min_x_o  (box_min_x_o),
  .box_max_x_o  (box_max_x_o),
  .box_max_y_o  (box_max_y_o),
  .last_of_run_o(last_of_run_o)
);

FILE: tb/sv/background_mask_bounding_box_core_test.sv
// Self-checking testbench for background_mask_bounding_box_core: drives BGR
// pixel frames with random pacing and checks every result against a predictor.
// Depends on bgbox_pkg and the core RTL.
`timescale 1ns / 100ps

module background_mask_bounding_box_core_test;
  import bgbox_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int REPORT_MAX   = 10;
  localparam int SCRIPT_LEN   = 25;

  typedef struct packed {
    logic [COORD_W-1:0] fg_x;
    logic [COORD_W-1:0] fg_y;
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] max_y;
    logic               last;
  } box_result_t;

  // One directed row; want is used only when typed is set
  typedef struct packed {
    logic        fs;
    pix_t        px;
    logic        typed;
    box_result_t want;
  } stim_row_t;

  localparam pix_t        BLACK = '0;
  localparam pix_t        WHITE = '1;
  localparam box_result_t NONE  = '0;

  logic               clk_i;
  logic               rst_n;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WIDTH_W-1:0] cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               frame_start;
  logic [PIX_W-1:0]   blue;
  logic [PIX_W-1:0]   green;
  logic [PIX_W-1:0]   red;
  logic               out_valid;
  logic               out_stall;
  logic [COORD_W-1:0] fg_x, fg_y, box_min_x, box_max_x, box_min_y, box_max_y;
  logic               last_of_run;

  background_mask_bounding_box_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .frame_start_i (frame_start),
    .blue_i        (blue),
    .green_i       (green),
    .red_i         (red),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .fg_x_o        (fg_x),
    .fg_y_o        (fg_y),
    .box_min_x_o   (box_min_x),
    .box_max_x_o   (box_max_x),
    .box_min_y_o   (box_min_y),
    .box_max_y_o   (box_max_y),
    .last_of_run_o (last_of_run)
  );

  // Predictor state: configuration, background seed set, counters, box
  logic [WIDTH_W-1:0] width_reg = WIDTH_RESET;
  logic [TOL_W-1:0]   tol_reg   = TOL_RESET;
  int   sum_b = 0, sum_g = 0, sum_r = 0;
  pix_t seed_px [SEED_COUNT];
  int   seed_x [SEED_COUNT];
  int   seed_y [SEED_COUNT];
  int   seed_n = 0;
  int   col = 0, row = 0;
  int   x_lo = 0, x_hi = 0, y_first = 0, y_last = 0;
  bit   box_seen = 1'b0;

  box_result_t boxes_due [$];
  stim_row_t   script [SCRIPT_LEN];
  box_result_t got, want;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  bit          quiet_run = 1'b0;
  int          stall_mode = 0;
  int          stall_hold = 0;
  int          stall_age = 0;

  // Channel differs from the seed mean by more than the tolerance (exact)
  function automatic bit chan_off(int sum, logic [PIX_W-1:0] p);
    int d;
    d = sum - SEED_COUNT * int'(p);
    if (d < 0) d = -d;
    return d > SEED_COUNT * int'(tol_reg);
  endfunction

  // Judge one pixel; on foreground grow the box and fill res
  function automatic bit judge_pixel(pix_t px, int x, int y, output box_result_t res);
    res = NONE;
    if (!(chan_off(sum_b, px.blue) || chan_off(sum_g, px.green) ||
          chan_off(sum_r, px.red)))
      return 1'b0;
    if (!box_seen) begin
      x_lo     = x;
      x_hi     = x;
      y_first  = y;
      box_seen = 1'b1;
    end else begin
      if (x < x_lo) x_lo = x;
      if (x > x_hi) x_hi = x;
    end
    y_last    = y;
    res.fg_x  = COORD_W'(x);
    res.fg_y  = COORD_W'(y);
    res.min_x = COORD_W'(x_lo);
    res.max_x = COORD_W'(x_hi);
    res.min_y = COORD_W'(y_first);
    res.max_y = COORD_W'(y_last);
    return 1'b1;
  endfunction

  // Advance the predictor by one pixel and queue the boxes it produces
  function automatic int predict_boxes(logic fs, pix_t px);
    box_result_t run [SEED_COUNT];
    box_result_t res;
    int n;
    int w;
    n = 0;
    if (fs) begin
      sum_b    = 0;
      sum_g    = 0;
      sum_r    = 0;
      seed_n   = 0;
      col      = 0;
      row      = 0;
      box_seen = 1'b0;
    end
    w = int'(width_reg);
    if (w == 0) w = 1;
    else if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (seed_n < SEED_COUNT) begin
      seed_px[seed_n] = px;
      seed_x[seed_n]  = col;
      seed_y[seed_n]  = row;
      seed_n++;
      sum_b += px.blue;
      sum_g += px.green;
      sum_r += px.red;
      // Seed set complete: judge the held pixels in arrival order
      if (seed_n == SEED_COUNT) begin
        for (int i = 0; i < SEED_COUNT; i++) begin
          if (judge_pixel(seed_px[i], seed_x[i], seed_y[i], res)) begin
            run[n] = res;
            n++;
          end
        end
      end
    end else if (judge_pixel(px, col, row, res)) begin
      run[0] = res;
      n = 1;
    end
    if (n > 0) run[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) boxes_due.push_back(run[i]);
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= MAX_HEIGHT) row = 0;
    end
    return n;
  endfunction

  function automatic logic [PIX_W-1:0] near_chan(logic [PIX_W-1:0] c, int spread);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return PIX_W'(v);
  endfunction

  function automatic pix_t near_pix(pix_t base, int spread);
    pix_t p;
    p.blue  = near_chan(base.blue, spread);
    p.green = near_chan(base.green, spread);
    p.red   = near_chan(base.red, spread);
    return p;
  endfunction

  function automatic pix_t rand_pix();
    return pix_t'(24'($urandom()));
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // End the run if it hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("background_mask_bounding_box_core_test: done, errors");
    $finish;
  end

  // Receiver stall pattern: idle, choppy or long holds, re-picked now and then
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      stall_age++;
      if (stall_age >= 64) begin
        stall_age  = 0;
        stall_mode = $urandom_range(0, 2);
      end
      if (quiet_run) begin
        stall_hold = 0;
        out_stall  = 1'b0;
      end else if (stall_hold > 0) begin
        stall_hold--;
      end else begin
        case (stall_mode)
          1: out_stall = ($urandom_range(0, 2) == 0);
          2: begin
            if ($urandom_range(0, 7) == 0) begin
              out_stall  = 1'b1;
              stall_hold = $urandom_range(2, 10);
            end else begin
              out_stall = 1'b0;
            end
          end
          default: out_stall = 1'b0;
        endcase
      end
    end
  end

  // Check each output transaction against the oldest expected box
  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall) begin
      got = '{fg_x, fg_y, box_min_x, box_max_x, box_min_y, box_max_y, last_of_run};
      if (boxes_due.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("unexpected result: x=%0d y=%0d box x %0d..%0d y %0d..%0d last=%0b",
                   got.fg_x, got.fg_y, got.min_x, got.max_x, got.min_y, got.max_y,
                   got.last);
        mismatches++;
      end else begin
        want = boxes_due.pop_front();
        if (got.fg_x !== want.fg_x || got.fg_y !== want.fg_y ||
            got.min_x !== want.min_x || got.max_x !== want.max_x ||
            got.min_y !== want.min_y || got.max_y !== want.max_y ||
            got.last !== want.last) begin
          if (mismatches < REPORT_MAX) begin
            $write("mismatch: want x=%0d y=%0d box x %0d..%0d y %0d..%0d last=%0b,",
                   want.fg_x, want.fg_y, want.min_x, want.max_x, want.min_y,
                   want.max_y, want.last);
            $display(" got x=%0d y=%0d box x %0d..%0d y %0d..%0d last=%0b",
                     got.fg_x, got.fg_y, got.min_x, got.max_x, got.min_y,
                     got.max_y, got.last);
          end
          mismatches++;
        end
      end
    end
  end

  // Send one pixel in bursts with random gaps; predict on acceptance.
  // A typed row replaces the predicted boxes with the one written in the table.
  task automatic send_pixel(logic fs, pix_t px, logic typed, box_result_t typed_box);
    int gap;
    int n;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (quiet_run) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(5, 20);
      else gap = $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid    = 1'b1;
    frame_start = fs;
    blue        = px.blue;
    green       = px.green;
    red         = px.red;
    do @(posedge clk_i); while (in_stall);
    n = predict_boxes(fs, px);
    if (typed) begin
      repeat (n) void'(boxes_due.pop_back());
      boxes_due.push_back(typed_box);
    end
    @(negedge clk_i);
  endtask

  // Well-formed frame: seeds near a base color, then mostly background
  task automatic send_frame(int len);
    pix_t base;
    pix_t px;
    int   spread;
    base   = rand_pix();
    spread = $urandom_range(0, 4);
    for (int i = 0; i < len; i++) begin
      if (i >= SEED_COUNT && $urandom_range(0, 3) == 0) px = rand_pix();
      else px = near_pix(base, spread);
      send_pixel(i == 0, px, 1'b0, NONE);
    end
  endtask

  // Mix of full frames, short frames and stray pixels
  task automatic run_random(int n_items);
    int sent;
    int kind;
    int len;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_pixel(1'($urandom_range(0, 1)), rand_pix(), 1'b0, NONE);
        sent++;
      end else begin
        if (kind == 1) len = $urandom_range(1, SEED_COUNT - 1);
        else len = $urandom_range(SEED_COUNT, 40);
        send_frame(len);
        sent += len;
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WIDTH_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
    if (idx == CFG_IMAGE_WIDTH) width_reg = data;
    else tol_reg = TOL_W'(data);
  endtask

  // Drain, reconfigure while idle, then run random traffic
  task automatic run_phase(int width, int tol, int n_items, int long_len, bit quiet);
    in_valid = 1'b0;
    while (boxes_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    write_reg(CFG_IMAGE_WIDTH, WIDTH_W'(width));
    write_reg(CFG_TOLERANCE, WIDTH_W'(tol));
    quiet_run = quiet;
    if (long_len > 0) send_frame(long_len);
    run_random(n_items);
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_IMAGE_WIDTH;
    cfg_data    = '0;
    in_valid    = 1'b0;
    frame_start = 1'b0;
    blue        = '0;
    green       = '0;
    red         = '0;

    // Directed rows at reset config (width 640, tolerance 5); pixels are {r,g,b}
    script = '{
      // stream with no frame start after reset: black seeds, no boxes
      '{1'b0, BLACK, 1'b0, NONE},
      '{1'b0, BLACK, 1'b0, NONE},
      '{1'b0, BLACK, 1'b0, NONE},
      '{1'b0, BLACK, 1'b0, NONE},
      '{1'b0, BLACK, 1'b0, NONE},
      '{1'b0, WHITE, 1'b1, '{12'd5, 12'd0, 12'd5, 12'd5, 12'd0, 12'd0, 1'b1}},
      // exactly at the tolerance: still background
      '{1'b0, '{8'd5, 8'd5, 8'd5}, 1'b0, NONE},
      '{1'b0, '{8'd0, 8'd6, 8'd0}, 1'b1, '{12'd7, 12'd0, 12'd5, 12'd7, 12'd0, 12'd0, 1'b1}},
      '{1'b0, '{8'd6, 8'd0, 8'd0}, 1'b0, NONE},
      // short frame, dropped by the next frame start
      '{1'b1, '{8'd30, 8'd20, 8'd10}, 1'b0, NONE},
      '{1'b0, '{8'd30, 8'd20, 8'd10}, 1'b0, NONE},
      '{1'b0, '{8'd30, 8'd20, 8'd10}, 1'b0, NONE},
      // every seed is foreground: five-box burst
      '{1'b1, BLACK, 1'b0, NONE},
      '{1'b0, BLACK, 1'b0, NONE},
      '{1'b0, BLACK, 1'b0, NONE},
      '{1'b0, BLACK, 1'b0, NONE},
      '{1'b0, '{8'd255, 8'd0, 8'd0}, 1'b0, NONE},
      '{1'b0, '{8'd51, 8'd0, 8'd0}, 1'b0, NONE},
      // white background, black foreground in a fresh frame
      '{1'b1, WHITE, 1'b0, NONE},
      '{1'b0, WHITE, 1'b0, NONE},
      '{1'b0, WHITE, 1'b0, NONE},
      '{1'b0, WHITE, 1'b0, NONE},
      '{1'b0, WHITE, 1'b0, NONE},
      '{1'b0, WHITE, 1'b0, NONE},
      '{1'b0, BLACK, 1'b1, '{12'd6, 12'd0, 12'd6, 12'd6, 12'd0, 12'd0, 1'b1}}
    };

    repeat (2) @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < SCRIPT_LEN; k++)
      send_pixel(script[k].fs, script[k].px, script[k].typed, script[k].want);

    // width, tolerance, items, long frame, quiet
    run_phase(5, 0, 40, 0, 1'b0);
    run_phase(4096, 255, 25, 0, 1'b0);
    // width 0 acts as 1: every pixel starts a new row
    run_phase(0, 12, 25, 0, 1'b0);
    run_phase(8191, 3, 45, 0, 1'b1);
    run_phase(13, 20, 55, 0, 1'b0);
    run_phase(640, 7, 55, 0, 1'b0);

    // Drain and finish
    in_valid = 1'b0;
    while (boxes_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0)
      $display("background_mask_bounding_box_core_test: done, clean");
    else
      $display("background_mask_bounding_box_core_test: done, errors");
    $finish;
  end

endmodule
